[rtl/hkrd_pkg.sv]
// Shared types and constants for the key report decoder.
// Used by the controller, the datapath and the top level; no dependencies.
package hkrd_pkg;

  // Header bytes and their positions within a report.
  localparam logic [7:0] HdrByte0 = 8'h41;
  localparam logic [7:0] HdrByte1 = 8'h43;
  localparam logic [7:0] HdrByte2 = 8'h4b;
  localparam logic [7:0] HdrByte5 = 8'h4f;
  localparam logic [7:0] HdrByte6 = 8'h4b;

  localparam logic [3:0] PosKeyId    = 4'd9;
  localparam logic [3:0] PosPress    = 4'd10;
  localparam logic [3:0] PosComplete = 4'd11;

  // The press flag counts only when it equals this value.
  localparam logic [7:0] PressValue = 8'h01;

  // Knob and extra-button id tables.
  localparam int unsigned KnobTableSize = 3;
  localparam int unsigned DefaultKnobCount = 3;
  localparam logic [7:0] KnobClickId [KnobTableSize] = '{8'h33, 8'h35, 8'h34};
  localparam logic [7:0] KnobCcwId   [KnobTableSize] = '{8'h90, 8'h50, 8'h60};
  localparam logic [7:0] KnobCwId    [KnobTableSize] = '{8'h91, 8'h51, 8'h61};
  localparam logic [7:0] ExtraId     [KnobTableSize] = '{8'h25, 8'h30, 8'h31};

  // Event kinds.
  localparam logic [2:0] EvGridKey   = 3'd0;
  localparam logic [2:0] EvKnobClick = 3'd1;
  localparam logic [2:0] EvKnobTurn  = 3'd2;
  localparam logic [2:0] EvExtraBtn  = 3'd3;
  localparam logic [2:0] EvSideKey   = 3'd4;

  // Turn directions.
  localparam logic signed [1:0] TurnNone = 2'sd0;
  localparam logic signed [1:0] TurnCw   = 2'sd1;
  localparam logic signed [1:0] TurnCcw  = -2'sd1;

  // Configuration register indexes (byte address divided by four).
  localparam logic [2:0] RegMode     = 3'd0;
  localparam logic [2:0] RegRows     = 3'd1;
  localparam logic [2:0] RegColumns  = 3'd2;
  localparam logic [2:0] RegSideKeys = 3'd3;
  localparam logic [2:0] RegExtraBtn = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [3:0] RowsReset     = 4'd3;
  localparam logic [3:0] ColumnsReset  = 4'd5;
  localparam logic [3:0] SideKeysReset = 4'd3;

  // Bits of the key id, which is also the length of the division.
  localparam int unsigned IdWidth = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;  // a byte transfer completes this cycle
    logic div_step;   // run one step of the divider
    logic load_out;   // decode and load the output register
  } hkrd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic report_done;  // the byte taken now ends a valid report
    logic div_last;     // the divider runs its final step
    logic out_free;     // the output register can take a new result
  } hkrd_sts_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic       knob_mode;
    logic [3:0] rows;
    logic [3:0] columns;
    logic [3:0] side_keys;
    logic [1:0] extra_buttons;
  } hkrd_cfg_t;

endpackage

[rtl/hkrd_ctrl.sv]
// Controller state machine of the key report decoder.
// Depends on hkrd_pkg for the command and status structs.
module hkrd_ctrl
  import hkrd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  hkrd_sts_t sts_i,
  output hkrd_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StEmit
  } state_e;

  state_e state_q, state_d;
  logic   in_stall_q, in_stall_d;

  // Next state: divide after a complete report, then hand the result over.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i && sts_i.report_done) begin
          state_d = StDivide;
        end
      end
      StDivide: begin
        if (sts_i.div_last) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    in_stall_d = (state_d != StIdle);
  end

  // State and the registered stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      in_stall_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_stall_q <= in_stall_d;
    end
  end

  // Commands follow from the state.
  always_comb begin
    cmd_o.take_byte = (state_q == StIdle) && in_valid_i;
    cmd_o.div_step  = (state_q == StDivide);
    cmd_o.load_out  = (state_q == StEmit) && sts_i.out_free;
  end

  assign in_stall_o = in_stall_q;

endmodule

[rtl/hkrd_datapath.sv]
// Datapath of the key report decoder: header check, id capture, a bit-serial
// divider and the id decode into the output register. Depends on hkrd_pkg.
module hkrd_datapath
  import hkrd_pkg::*;
#(
  parameter int unsigned KnobCount = DefaultKnobCount
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hkrd_cmd_t               cmd_i,
  output hkrd_sts_t               sts_o,
  input  hkrd_cfg_t               cfg_i,
  input  logic [7:0]              report_byte_i,
  input  logic                    last_byte_i,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic [2:0]              event_kind_o,
  output logic [2:0]              key_row_o,
  output logic [2:0]              key_column_o,
  output logic [2:0]              control_index_o,
  output logic                    is_pressed_o,
  output logic signed [1:0]       turn_direction_o
);

  localparam int unsigned CntWidth = $clog2(IdWidth);

  // Report tracking state.
  logic [3:0]         pos_q, pos_d;
  logic               hdr_ok_q, hdr_ok_d;
  logic [IdWidth-1:0] held_id_q;
  logic               held_press_q, held_press_d;
  logic               byte_match;
  logic [3:0]         pos_inc;

  // Operands captured for decode, and the divider.
  logic [IdWidth-1:0]  dec_id_q;
  logic                dec_press_q;
  logic [3:0]          dvs_q;
  logic [3:0]          rem_q;
  logic [IdWidth-1:0]  quot_q;
  logic [CntWidth-1:0] cnt_q;
  logic [4:0]          rem_sh;
  logic                rem_ge;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [2:0]        kind_q, row_q, col_q, idx_q;
  logic              press_q;
  logic signed [1:0] dir_q;

  // Header compare for the byte at the current position.
  always_comb begin
    byte_match = 1'b1;
    case (pos_q)
      4'd0:    byte_match = (report_byte_i == HdrByte0);
      4'd1:    byte_match = (report_byte_i == HdrByte1);
      4'd2:    byte_match = (report_byte_i == HdrByte2);
      4'd5:    byte_match = (report_byte_i == HdrByte5);
      4'd6:    byte_match = (report_byte_i == HdrByte6);
      default: byte_match = 1'b1;
    endcase
    pos_inc      = (pos_q < PosComplete) ? pos_q + 4'd1 : pos_q;
    held_press_d = (pos_q == PosPress) ? (report_byte_i == PressValue) : held_press_q;
    hdr_ok_d     = hdr_ok_q & byte_match;
    pos_d        = pos_inc;
  end

  // The byte offered now would end a complete report with a good header.
  assign sts_o.report_done = last_byte_i && (pos_inc == PosComplete) && hdr_ok_d;

  // Report tracking; a last byte returns the tracking to its reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= 4'd0;
      hdr_ok_q     <= 1'b1;
      held_press_q <= 1'b0;
    end else if (cmd_i.take_byte) begin
      if (last_byte_i) begin
        pos_q        <= 4'd0;
        hdr_ok_q     <= 1'b1;
        held_press_q <= 1'b0;
      end else begin
        pos_q        <= pos_d;
        hdr_ok_q     <= hdr_ok_d;
        held_press_q <= held_press_d;
      end
    end
  end

  // Key id capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && (pos_q == PosKeyId)) begin
      held_id_q <= report_byte_i;
    end
  end

  // One restoring division step per cycle.
  assign rem_sh = {rem_q, quot_q[IdWidth-1]};
  assign rem_ge = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.take_byte) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && sts_o.report_done) begin
      dec_id_q    <= held_id_q;
      dec_press_q <= held_press_d;
      dvs_q       <= cfg_i.knob_mode ? cfg_i.columns : cfg_i.rows;
      rem_q       <= 4'd0;
      quot_q      <= held_id_q - IdWidth'(1);
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? 4'(rem_sh - {1'b0, dvs_q}) : rem_sh[3:0];
      quot_q <= {quot_q[IdWidth-2:0], rem_ge};
    end
  end

  assign sts_o.div_last = cmd_i.div_step && (cnt_q == CntWidth'(IdWidth - 1));

  // Id decode: grid first, then knob and extra-button tables or side keys.
  logic [7:0]        keys;
  logic [8:0]        side_end;
  logic              grid_hit, hit;
  logic [2:0]        kind_n, row_n, col_n, idx_n;
  logic              press_n;
  logic signed [1:0] dir_n;
  logic [7:0]        col_full, side_idx;

  always_comb begin
    keys     = {4'd0, cfg_i.rows} * {4'd0, cfg_i.columns};
    side_end = {1'b0, keys} + {5'd0, cfg_i.side_keys};
    grid_hit = (dec_id_q != '0) && (dec_id_q <= keys);
    col_full = {4'd0, cfg_i.columns} - 8'd1 - quot_q;
    side_idx = dec_id_q - keys - 8'd1;
    hit      = 1'b0;
    kind_n   = EvGridKey;
    row_n    = 3'd0;
    col_n    = 3'd0;
    idx_n    = 3'd0;
    press_n  = dec_press_q;
    dir_n    = TurnNone;
    if (grid_hit) begin
      hit = 1'b1;
      if (cfg_i.knob_mode) begin
        row_n = quot_q[2:0];
        col_n = rem_q[2:0];
      end else begin
        row_n = rem_q[2:0];
        col_n = col_full[2:0];
      end
    end else if (cfg_i.knob_mode) begin
      for (int i = 0; i < KnobTableSize; i++) begin
        if (!hit && (i < KnobCount)) begin
          if (dec_id_q == KnobClickId[i]) begin
            hit    = 1'b1;
            kind_n = EvKnobClick;
            idx_n  = 3'(i);
          end else if (dec_id_q == KnobCwId[i]) begin
            hit     = 1'b1;
            kind_n  = EvKnobTurn;
            idx_n   = 3'(i);
            press_n = 1'b0;
            dir_n   = TurnCw;
          end else if (dec_id_q == KnobCcwId[i]) begin
            hit     = 1'b1;
            kind_n  = EvKnobTurn;
            idx_n   = 3'(i);
            press_n = 1'b0;
            dir_n   = TurnCcw;
          end
        end
      end
      for (int j = 0; j < KnobTableSize; j++) begin
        if (!hit && (j < int'(cfg_i.extra_buttons)) && (dec_id_q == ExtraId[j])) begin
          hit    = 1'b1;
          kind_n = EvExtraBtn;
          idx_n  = 3'(j);
        end
      end
    end else if ({1'b0, dec_id_q} > {1'b0, keys} && {1'b0, dec_id_q} <= side_end) begin
      hit    = 1'b1;
      kind_n = EvSideKey;
      idx_n  = side_idx[2:0];
    end
  end

  // Output register; a result waits here until its transfer.
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_d    = (cmd_i.load_out && hit) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out && hit) begin
      kind_q  <= kind_n;
      row_q   <= row_n;
      col_q   <= col_n;
      idx_q   <= idx_n;
      press_q <= press_n;
      dir_q   <= dir_n;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = kind_q;
  assign key_row_o        = row_q;
  assign key_column_o     = col_q;
  assign control_index_o  = idx_q;
  assign is_pressed_o     = press_q;
  assign turn_direction_o = dir_q;

endmodule

[rtl/hid_key_report_decoder.sv]
// Channel   Direction  Handshake             Payload
// input     in         in_valid_i/in_stall_o report_byte_i, last_byte_i
// result    out        out_valid_o/out_stall_i event_kind_o .. turn_direction_o
// config    in         APB psel/penable      paddr, pwdata, prdata
//
// The last byte of a valid report starts a bit-serial divider (one quotient
// bit per cycle) and then the id decode, which loads the output register once
// that is free; the input stalls from the last byte until that load.
// Reset is asynchronous and active low; it needs no clearing pass.
// The output register holds one result; while it is stalled the input stalls
// only once a further report completes.
// Top level of the key report decoder: configuration registers, controller
// and datapath. Depends on hkrd_pkg, hkrd_ctrl and hkrd_datapath.
module hid_key_report_decoder
  import hkrd_pkg::*;
#(
  parameter int unsigned KnobCount = DefaultKnobCount
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        report_byte_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        event_kind_o,
  output logic [2:0]        key_row_o,
  output logic [2:0]        key_column_o,
  output logic [2:0]        control_index_o,
  output logic              is_pressed_o,
  output logic signed [1:0] turn_direction_o
);

  hkrd_cfg_t cfg_q;
  hkrd_cmd_t cmd;
  hkrd_sts_t sts;
  logic      wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.knob_mode     <= 1'b0;
      cfg_q.rows          <= RowsReset;
      cfg_q.columns       <= ColumnsReset;
      cfg_q.side_keys     <= SideKeysReset;
      cfg_q.extra_buttons <= 2'd0;
    end else if (wr_en) begin
      case (reg_idx)
        RegMode:     cfg_q.knob_mode     <= pwdata[0];
        RegRows:     cfg_q.rows          <= pwdata[3:0];
        RegColumns:  cfg_q.columns       <= pwdata[3:0];
        RegSideKeys: cfg_q.side_keys     <= pwdata[3:0];
        RegExtraBtn: cfg_q.extra_buttons <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Configuration register reads.
  always_comb begin
    case (reg_idx)
      RegMode:     prdata = {31'd0, cfg_q.knob_mode};
      RegRows:     prdata = {28'd0, cfg_q.rows};
      RegColumns:  prdata = {28'd0, cfg_q.columns};
      RegSideKeys: prdata = {28'd0, cfg_q.side_keys};
      RegExtraBtn: prdata = {30'd0, cfg_q.extra_buttons};
      default:     prdata = 32'd0;
    endcase
  end

  hkrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hkrd_datapath #(
    .KnobCount (KnobCount)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_i            (cfg_q),
    .report_byte_i    (report_byte_i),
    .last_byte_i      (last_byte_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .event_kind_o     (event_kind_o),
    .key_row_o        (key_row_o),
    .key_column_o     (key_column_o),
    .control_index_o  (control_index_o),
    .is_pressed_o     (is_pressed_o),
    .turn_direction_o (turn_direction_o)
  );

endmodule

[verif/hid_key_report_decoder_tb.sv]
// Self-checking testbench for hid_key_report_decoder: random and directed reports
// go in, and each decoded key event is checked against a cycle-free predictor.
// Depends on hkrd_pkg and on the RTL of the decoder only.
module hid_key_report_decoder_tb;
  import hkrd_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned ByteTarget  = 850;
  localparam int unsigned EventTarget = 60;
  localparam int unsigned IdlePercent = 34;

  // One decoded key event, laid out in port order.
  typedef struct packed {
    logic [2:0]        kind;
    logic [2:0]        row;
    logic [2:0]        col;
    logic [2:0]        idx;
    logic              pressed;
    logic signed [1:0] dir;
  } key_event_t;

  typedef struct {
    bit mode;
    int rows;
    int cols;
    int side;
    int extra;
  } panel_cfg_t;

  // Predicts the key events of a byte stream and checks the observed ones.
  class key_event_scoreboard;
    bit         knob_mode;
    logic [3:0] rows;
    logic [3:0] cols;
    logic [3:0] side;
    logic [1:0] extra;

    logic [3:0] byte_pos;
    bit         header_ok;
    logic [7:0] key_id;
    bit         press;

    key_event_t  pending_events[$];
    int unsigned bytes_taken;
    int unsigned events_predicted;
    int unsigned mismatch_count;

    function new();
      knob_mode = 1'b0;
      rows = RowsReset;
      cols = ColumnsReset;
      side = SideKeysReset;
      extra = 2'd0;
      byte_pos = 4'd0;
      header_ok = 1'b1;
      key_id = 8'd0;
      press = 1'b0;
    endfunction

    task report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
    endtask

    function logic [31:0] reg_mask(input logic [2:0] index);
      case (index)
        RegMode:     return 32'h1;
        RegExtraBtn: return 32'h3;
        default:     return 32'hf;
      endcase
    endfunction

    function void set_reg(input logic [2:0] index, input logic [31:0] value);
      case (index)
        RegMode:     knob_mode = value[0];
        RegRows:     rows = value[3:0];
        RegColumns:  cols = value[3:0];
        RegSideKeys: side = value[3:0];
        RegExtraBtn: extra = value[1:0];
        default: ;
      endcase
    endfunction

    // Maps the held key id onto an event under the current panel layout.
    function bit decode_key(output key_event_t ev);
      int unsigned id;
      int unsigned keys;
      int unsigned n;
      id = key_id;
      keys = int'(rows) * int'(cols);
      ev = '0;
      ev.dir = TurnNone;
      ev.pressed = press;
      // Grid ids take precedence over every table.
      if (id >= 1 && id <= keys) begin
        n = id - 1;
        ev.kind = EvGridKey;
        if (knob_mode) begin
          ev.row = 3'(n / cols);
          ev.col = 3'(n % cols);
        end else begin
          ev.col = 3'(cols - 1 - n / rows);
          ev.row = 3'(n % rows);
        end
        return 1'b1;
      end
      if (knob_mode) begin
        for (int i = 0; i < KnobTableSize; i++) begin
          ev.idx = 3'(i);
          if (id == KnobClickId[i]) begin
            ev.kind = EvKnobClick;
            return 1'b1;
          end
          if (id == KnobCwId[i] || id == KnobCcwId[i]) begin
            ev.kind = EvKnobTurn;
            ev.pressed = 1'b0;
            ev.dir = (id == KnobCwId[i]) ? TurnCw : TurnCcw;
            return 1'b1;
          end
        end
        for (int i = 0; i < extra; i++) begin
          if (id == ExtraId[i]) begin
            ev.kind = EvExtraBtn;
            ev.idx = 3'(i);
            return 1'b1;
          end
        end
        return 1'b0;
      end
      // Outside knob mode the side keys follow the grid ids.
      if (id > keys && id <= keys + side) begin
        ev.kind = EvSideKey;
        ev.idx = 3'(id - keys - 1);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Notes one accepted byte transfer and queues the event it completes.
    function void note_byte(input logic [7:0] b, input logic lst);
      key_event_t ev;
      bytes_taken++;
      case (byte_pos)
        4'd0: if (b != HdrByte0) header_ok = 1'b0;
        4'd1: if (b != HdrByte1) header_ok = 1'b0;
        4'd2: if (b != HdrByte2) header_ok = 1'b0;
        4'd5: if (b != HdrByte5) header_ok = 1'b0;
        4'd6: if (b != HdrByte6) header_ok = 1'b0;
        PosKeyId: key_id = b;
        PosPress: press = (b == PressValue);
        default: ;
      endcase
      if (byte_pos < PosComplete) byte_pos++;
      if (lst) begin
        if (byte_pos == PosComplete && header_ok && decode_key(ev)) begin
          pending_events.push_back(ev);
          events_predicted++;
        end
        byte_pos = 4'd0;
        header_ok = 1'b1;
        press = 1'b0;
      end
    endfunction

    task check_event(input key_event_t got);
      key_event_t want;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("event kind %0d idx %0d with none expected",
                                  got.kind, got.idx));
        return;
      end
      want = pending_events.pop_front();
      if (got.kind != want.kind || got.row != want.row || got.col != want.col ||
          got.idx != want.idx || got.pressed != want.pressed || got.dir != want.dir) begin
        report_mismatch($sformatf(
          "got kind %0d row %0d col %0d idx %0d pressed %0d dir %0d, expected %0d %0d %0d %0d %0d %0d",
          got.kind, got.row, got.col, got.idx, got.pressed, got.dir,
          want.kind, want.row, want.col, want.idx, want.pressed, want.dir));
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [4:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        report_byte_i = '0;
  logic              last_byte_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [2:0]        event_kind_o;
  logic [2:0]        key_row_o;
  logic [2:0]        key_column_o;
  logic [2:0]        control_index_o;
  logic              is_pressed_o;
  logic signed [1:0] turn_direction_o;

  key_event_scoreboard sb = new();
  bit          tx_idling = 1'b1;
  bit          rx_idling = 1'b1;
  bit          hold_go = 1'b0;
  logic        hold_on = 1'b0;
  int unsigned cycle_count = 0;

  hid_key_report_decoder uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .report_byte_i    (report_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_kind_o     (event_kind_o),
    .key_row_o        (key_row_o),
    .key_column_o     (key_column_o),
    .control_index_o  (control_index_o),
    .is_pressed_o     (is_pressed_o),
    .turn_direction_o (turn_direction_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver stall: random idling plus one long hold-off.
  always @(posedge clk_i) begin
    out_stall_i <= hold_on || (rx_idling && $urandom_range(99) < IdlePercent);
  end

  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // Result monitor: a transfer seen stable at the falling edge completes at the next rise.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_event({event_kind_o, key_row_o, key_column_o, control_index_o,
                      is_pressed_o, turn_direction_o});
    end
  end

  // Offers one byte and returns at the edge where its transfer completes.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    bit taken;
    while (tx_idling && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    report_byte_i <= b;
    last_byte_i <= lst;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    sb.note_byte(b, lst);
  endtask

  // Sends a report with a good header; bad_pos, when not negative, corrupts that byte.
  task automatic send_report(input logic [7:0] id, input logic [7:0] flag, input int len,
                             input int bad_pos);
    logic [7:0] b;
    for (int k = 0; k < len; k++) begin
      b = 8'($urandom_range(255));
      case (k)
        0: b = HdrByte0;
        1: b = HdrByte1;
        2: b = HdrByte2;
        5: b = HdrByte5;
        6: b = HdrByte6;
        9: b = id;
        10: b = flag;
        default: ;
      endcase
      if (k == bad_pos) b = b ^ 8'($urandom_range(255, 1));
      send_byte(b, k == len - 1);
    end
  endtask

  // APB write followed by a read-back of the same register.
  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    logic [31:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
    end while (!pready);
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
    end while (!pready);
    readback = prdata;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(index, value);
    if ((readback & sb.reg_mask(index)) != (value & sb.reg_mask(index))) begin
      sb.report_mismatch($sformatf("register %0d reads %0h after writing %0h",
                                   index, readback, value));
    end
  endtask

  // Waits until every predicted event has come out, then lets the block settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic panel_cfg_t phase_cfg(input int p);
    panel_cfg_t c;
    case (p)
      1: c = '{1'b1, 3, 5, 3, 3};
      2: c = '{1'b1, 8, 8, 0, 3};
      3: c = '{1'b0, 1, 1, 0, 0};
      4: c = '{1'b0, 8, 8, 8, 0};
      5: c = '{1'b1, 1, 8, 2, 0};
      6: c = '{1'b0, 0, 5, 4, 1};     // empty grid: only side keys decode
      7: c = '{1'b1, 12, 10, 5, 2};   // oversized grid, rows and columns wrap
      8: c = '{1'b0, 15, 15, 15, 1};
      default: c = '{1'($urandom_range(1)), $urandom_range(8, 1), $urandom_range(8, 1),
                     $urandom_range(8), $urandom_range(3)};
    endcase
    return c;
  endfunction

  // Draws ids from the grid, the side keys, the tables, zero and the whole byte range.
  function automatic logic [7:0] pick_key_id();
    int keys;
    keys = int'(sb.rows) * int'(sb.cols);
    case ($urandom_range(9))
      0, 1, 2, 3: return (keys > 0) ? 8'($urandom_range(keys, 1)) : 8'($urandom_range(255));
      4: return 8'(keys + $urandom_range(int'(sb.side) + 1, 1));
      5: begin
        case ($urandom_range(2))
          0: return KnobClickId[$urandom_range(2)];
          1: return KnobCwId[$urandom_range(2)];
          default: return KnobCcwId[$urandom_range(2)];
        endcase
      end
      6: return ExtraId[$urandom_range(2)];
      7: return 8'd0;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_press_byte();
    case ($urandom_range(3))
      0, 1: return PressValue;
      2: return 8'd0;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic int pick_header_pos();
    case ($urandom_range(4))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 5;
      default: return 6;
    endcase
  endfunction

  // Mostly well-formed reports, then broken reports and raw noise.
  task automatic send_random_item();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 80) begin
      len = ($urandom_range(5) == 0) ? $urandom_range(20, 12) : 11;
      send_report(pick_key_id(), pick_press_byte(), len, -1);
    end else if (pick < 90) begin
      if ($urandom_range(1)) send_report(pick_key_id(), PressValue, $urandom_range(10, 1), -1);
      else send_report(pick_key_id(), pick_press_byte(), 11, pick_header_pos());
    end else begin
      len = $urandom_range(16, 1);
      for (int k = 0; k < len; k++) begin
        send_byte(8'($urandom_range(255)), (k == len - 1) || ($urandom_range(7) == 0));
      end
    end
  endtask

  // Directed reports under the reset layout: grid, side keys, misses, length and header.
  task automatic directed_reset_layout();
    send_report(8'd1, PressValue, 11, -1);
    send_report(8'd15, 8'd0, 11, -1);
    send_report(8'd16, PressValue, 11, -1);
    send_report(8'd18, 8'd2, 11, -1);
    send_report(8'd19, PressValue, 11, -1);
    send_report(8'd0, PressValue, 11, -1);
    send_report(KnobClickId[0], PressValue, 11, -1);
    send_report(8'd1, PressValue, 10, -1);
    send_report(8'd7, PressValue, 20, -1);
    send_report(8'd1, PressValue, 11, 0);
    send_report(8'd1, PressValue, 11, 1);
    send_report(8'd1, PressValue, 11, 2);
    send_report(8'd1, PressValue, 11, 5);
    send_report(8'd1, PressValue, 11, 6);
  endtask

  // Directed reports in knob mode: every table entry, the last grid id and a side id.
  task automatic directed_knob_layout();
    for (int i = 0; i < KnobTableSize; i++) begin
      send_report(KnobClickId[i], PressValue, 11, -1);
      send_report(KnobCwId[i], PressValue, 11, -1);
      send_report(KnobCcwId[i], 8'd0, 11, -1);
      send_report(ExtraId[i], PressValue, 11, -1);
    end
    send_report(8'd15, PressValue, 11, -1);
    send_report(8'd16, PressValue, 11, -1);
  endtask

  initial begin
    int         phase;
    panel_cfg_t cfg;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    phase = 0;
    while (phase < 9 || sb.bytes_taken < ByteTarget || sb.events_predicted < EventTarget) begin
      if (phase > 0) begin
        wait_idle();
        cfg = phase_cfg(phase);
        write_reg(RegMode, 32'(cfg.mode));
        write_reg(RegRows, cfg.rows);
        write_reg(RegColumns, cfg.cols);
        write_reg(RegSideKeys, cfg.side);
        write_reg(RegExtraBtn, cfg.extra);
      end
      // One phase runs with no idling on either side.
      tx_idling = (phase != 3);
      rx_idling = (phase != 3);
      // Long receiver hold-off while reports keep coming.
      if (phase == 4) hold_go = 1'b1;
      case (phase)
        0: directed_reset_layout();
        1: directed_knob_layout();
        2: begin
          send_report(ExtraId[0], PressValue, 11, -1);
          send_report(ExtraId[1], PressValue, 11, -1);
          send_report(8'd64, PressValue, 11, -1);
          send_report(8'd65, PressValue, 11, -1);
        end
        default: ;
      endcase
      repeat (6) send_random_item();
      phase++;
    end

    wait_idle();
    if (sb.mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
